// ===== hw/rtl/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// Multinomial coefficient table package
// Shared constants, codes and types for the coefficient table block.
// ----------------------------------------------------------------------------
package mct_pkg;

  // Grid geometry: four dimensions of four exponent bits each.
  localparam int GridBits = 4;
  localparam int GridDims = 4;
  localparam int AddrW    = GridBits * GridDims;
  localparam int DimW     = $clog2(GridDims);

  // Limits of the simplex.
  localparam int MaxVariables = 4;
  localparam int MaxOrder     = 14;

  // Coefficient widths: stored width default and the fixed output field.
  localparam int CoefWidth = 23;
  localparam int OutCoefW  = 23;

  // Register and sum widths.
  localparam int VarW     = 3;
  localparam int OrderW   = 4;
  localparam int SumW     = 6;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  // Register reset values.
  localparam logic [VarW-1:0]   VarReset   = 3'd3;
  localparam logic [OrderW-1:0] OrderReset = 4'd4;

  // Item modes.
  localparam logic ModeBuild = 1'b0;
  localparam logic ModeQuery = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegVarCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegExpOrder = 2'd1;

  // Result of a tuple check.
  typedef struct packed {
    logic ok;       // unused exponents are zero and the sum fits the order
    logic nonzero;  // the sum of the used exponents is not zero
  } chk_res_t;

endpackage

// ===== hw/rtl/mct_tuple_chk.sv =====
// ----------------------------------------------------------------------------
// Tuple check
// Decides whether an exponent tuple lies inside the simplex of a given
// variable count and order.
// ----------------------------------------------------------------------------
module mct_tuple_chk (
  input  logic [mct_pkg::AddrW-1:0]  addr_i,
  input  logic [mct_pkg::VarW-1:0]   vars_i,
  input  logic [mct_pkg::OrderW-1:0] order_i,
  output mct_pkg::chk_res_t          res_o
);

  logic [mct_pkg::SumW-1:0] sum;
  logic                     unused_nz;

  // Sum the used exponents and flag any nonzero unused one.
  always_comb begin
    sum       = '0;
    unused_nz = 1'b0;
    for (int d = 0; d < mct_pkg::GridDims; d++) begin
      if (mct_pkg::VarW'(d) < vars_i) begin
        sum = sum + mct_pkg::SumW'(addr_i[d*mct_pkg::GridBits +: mct_pkg::GridBits]);
      end else if (addr_i[d*mct_pkg::GridBits +: mct_pkg::GridBits] != '0) begin
        unused_nz = 1'b1;
      end
    end
    res_o.ok      = !unused_nz && (sum <= mct_pkg::SumW'(order_i));
    res_o.nonzero = (sum != '0);
  end

endmodule

// ===== hw/rtl/mct_sat_add.sv =====
// ----------------------------------------------------------------------------
// Saturating adder
// The shared arithmetic unit: adds one neighbor value into the running sum,
// clamping at the largest value of the coefficient width.
// ----------------------------------------------------------------------------
module mct_sat_add #(
  parameter int Width = mct_pkg::CoefWidth
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic [Width-1:0] sum_o
);

  logic [Width:0] full;

  // Carry out of the top bit means the true sum does not fit.
  assign full  = {1'b0, a_i} + {1'b0, b_i};
  assign sum_o = full[Width] ? '1 : full[Width-1:0];

endmodule

// ===== hw/rtl/mct_coef_mem.sv =====
// ----------------------------------------------------------------------------
// Coefficient memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mct_coef_mem #(
  parameter int Width = mct_pkg::CoefWidth
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [mct_pkg::AddrW-1:0] waddr_i,
  input  logic [Width-1:0]          wdata_i,
  input  logic                      re_i,
  input  logic [mct_pkg::AddrW-1:0] raddr_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem_q [2**mct_pkg::AddrW];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/multinomial_coefficient_table.sv =====
// ----------------------------------------------------------------------------
// Multinomial coefficient table
// Builds a generalized Pascal simplex of multinomial coefficients in a
// 64K-entry memory and answers coefficient queries from it.
// ----------------------------------------------------------------------------
// Usage: the configuration channel (cfg_valid_i/cfg_ready_o, always ready)
// sets the variable count (index 0) and the expansion order (index 1); the
// user must write them only while the block is idle, which the block itself
// does not enforce. Each input transfer is either a build (mode 0) or a
// query (mode 1); each produces exactly one output transfer.
// A query issues one memory read on acceptance; the registered read data is
// loaded into the output register once that is free, and only then does the
// sequencer return to idle and take a new item.
// A build writes the origin, then sweeps all 65535 grid addresses in order,
// passing over each address outside the simplex and, for each cell inside
// it, making four neighbor reads through the single read port, each followed
// by a pass through the shared saturating adder, and one write.
// Reset sets the registers to three variables and order four and marks the
// table as never built, so every query returns zero until the first build;
// no memory clearing pass is needed, since a query is also checked against
// the simplex of the last build. A stalled receiver holds the result in the
// output register; the block takes the next item meanwhile and waits only
// when that item's result is ready.
// ----------------------------------------------------------------------------
module multinomial_coefficient_table #(
  parameter int CoefWidth = mct_pkg::CoefWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mct_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mct_pkg::CfgDataW-1:0] cfg_data_i,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [mct_pkg::GridBits-1:0] exponent_a_i,
  input  logic [mct_pkg::GridBits-1:0] exponent_b_i,
  input  logic [mct_pkg::GridBits-1:0] exponent_c_i,
  input  logic [mct_pkg::GridBits-1:0] exponent_d_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mct_pkg::OutCoefW-1:0] coefficient_o,
  output logic                         build_done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_SCAN,
    S_RD,
    S_ADD,
    S_WR,
    S_QOUT,
    S_DONE
  } state_e;

  state_e                       state_q, state_d;
  logic [mct_pkg::VarW-1:0]     var_cnt_q, var_cnt_d;
  logic [mct_pkg::OrderW-1:0]   exp_order_q, exp_order_d;
  logic [mct_pkg::VarW-1:0]     eff_vars;
  logic [mct_pkg::OrderW-1:0]   eff_order;
  logic                         built_q, built_d;
  logic [mct_pkg::VarW-1:0]     built_vars_q, built_vars_d;
  logic [mct_pkg::OrderW-1:0]   built_order_q, built_order_d;
  logic [mct_pkg::AddrW-1:0]    addr_q, addr_d;
  logic [mct_pkg::DimW-1:0]     dim_q, dim_d;
  logic [CoefWidth-1:0]         acc_q, acc_d;
  logic                         elig_q, elig_d;
  logic                         out_valid_q, out_valid_d;
  logic [mct_pkg::OutCoefW-1:0] coef_q, coef_d;
  logic                         done_q, done_d;

  logic                         in_xfer;
  logic                         out_free;
  logic [mct_pkg::AddrW-1:0]    query_addr;
  logic [mct_pkg::AddrW-1:0]    nbr_addr;
  logic [mct_pkg::GridBits-1:0] dim_exp;
  logic                         mem_we;
  logic [mct_pkg::AddrW-1:0]    mem_waddr;
  logic [CoefWidth-1:0]         mem_wdata;
  logic                         mem_re;
  logic [mct_pkg::AddrW-1:0]    mem_raddr;
  logic [CoefWidth-1:0]         mem_rdata;
  logic [CoefWidth-1:0]         sat_sum;
  logic [CoefWidth-1:0]         query_coef;
  logic [mct_pkg::OutCoefW-1:0] query_out;
  mct_pkg::chk_res_t            chk_cur;
  mct_pkg::chk_res_t            chk_blt;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Effective register values after range clamping.
  always_comb begin
    if (var_cnt_q == '0) begin
      eff_vars = mct_pkg::VarW'(1);
    end else if (var_cnt_q > mct_pkg::VarW'(mct_pkg::MaxVariables)) begin
      eff_vars = mct_pkg::VarW'(mct_pkg::MaxVariables);
    end else begin
      eff_vars = var_cnt_q;
    end
    if (exp_order_q > mct_pkg::OrderW'(mct_pkg::MaxOrder)) begin
      eff_order = mct_pkg::OrderW'(mct_pkg::MaxOrder);
    end else begin
      eff_order = exp_order_q;
    end
  end

  // Addresses: the query tuple and the neighbor one step lower in dim_q.
  assign query_addr = {exponent_d_i, exponent_c_i, exponent_b_i, exponent_a_i};
  assign dim_exp    = addr_q[mct_pkg::GridBits*dim_q +: mct_pkg::GridBits];
  assign nbr_addr   = addr_q - (mct_pkg::AddrW'(1) << (mct_pkg::GridBits * dim_q));

  // Simplex checks against the current registers and the last build.
  mct_tuple_chk u_chk_cur (
    .addr_i  (addr_q),
    .vars_i  (eff_vars),
    .order_i (eff_order),
    .res_o   (chk_cur)
  );

  mct_tuple_chk u_chk_blt (
    .addr_i  (addr_q),
    .vars_i  (built_vars_q),
    .order_i (built_order_q),
    .res_o   (chk_blt)
  );

  // Shared saturating adder.
  mct_sat_add #(
    .Width (CoefWidth)
  ) u_sat_add (
    .a_i   (acc_q),
    .b_i   (mem_rdata),
    .sum_o (sat_sum)
  );

  // Coefficient memory.
  mct_coef_mem #(
    .Width (CoefWidth)
  ) u_coef_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Memory port control.
  assign mem_we    = (state_q == S_SEED) || (state_q == S_WR);
  assign mem_waddr = (state_q == S_SEED) ? '0 : addr_q;
  assign mem_wdata = (state_q == S_SEED) ? CoefWidth'(1) : acc_q;
  assign mem_re    = (in_xfer && (mode_i == mct_pkg::ModeQuery)) || (state_q == S_RD);
  assign mem_raddr = (state_q == S_IDLE) ? query_addr : nbr_addr;

  // A query hits only inside both the current and the last built simplex.
  assign query_coef = (built_q && chk_cur.ok && chk_blt.ok) ? mem_rdata : '0;

  // Fit the stored coefficient to the output field.
  if (CoefWidth >= mct_pkg::OutCoefW) begin : g_out_trunc
    assign query_out = query_coef[mct_pkg::OutCoefW-1:0];
  end else begin : g_out_ext
    assign query_out = {{(mct_pkg::OutCoefW-CoefWidth){1'b0}}, query_coef};
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d       = state_q;
    var_cnt_d     = var_cnt_q;
    exp_order_d   = exp_order_q;
    built_d       = built_q;
    built_vars_d  = built_vars_q;
    built_order_d = built_order_q;
    addr_d        = addr_q;
    dim_d         = dim_q;
    acc_d         = acc_q;
    elig_d        = elig_q;
    out_valid_d   = out_valid_q;
    coef_d        = coef_q;
    done_d        = done_q;

    // The receiver took the pending result.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Configuration writes.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mct_pkg::RegVarCount: var_cnt_d   = cfg_data_i[mct_pkg::VarW-1:0];
        mct_pkg::RegExpOrder: exp_order_d = cfg_data_i[mct_pkg::OrderW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (mode_i == mct_pkg::ModeQuery) begin
            addr_d  = query_addr;
            state_d = S_QOUT;
          end else begin
            built_d       = 1'b1;
            built_vars_d  = eff_vars;
            built_order_d = eff_order;
            state_d       = S_SEED;
          end
        end
      end
      S_SEED: begin
        addr_d  = mct_pkg::AddrW'(1);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (chk_cur.ok && chk_cur.nonzero) begin
          dim_d   = '0;
          acc_d   = '0;
          state_d = S_RD;
        end else if (addr_q == '1) begin
          state_d = S_DONE;
        end else begin
          addr_d = addr_q + mct_pkg::AddrW'(1);
        end
      end
      S_RD: begin
        elig_d  = (mct_pkg::VarW'(dim_q) < eff_vars) && (dim_exp != '0);
        state_d = S_ADD;
      end
      S_ADD: begin
        if (elig_q) begin
          acc_d = sat_sum;
        end
        if (dim_q == mct_pkg::DimW'(mct_pkg::GridDims - 1)) begin
          state_d = S_WR;
        end else begin
          dim_d   = dim_q + mct_pkg::DimW'(1);
          state_d = S_RD;
        end
      end
      S_WR: begin
        if (addr_q == '1) begin
          state_d = S_DONE;
        end else begin
          addr_d  = addr_q + mct_pkg::AddrW'(1);
          state_d = S_SCAN;
        end
      end
      S_QOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          coef_d      = query_out;
          done_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          coef_d      = '0;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      var_cnt_q     <= mct_pkg::VarReset;
      exp_order_q   <= mct_pkg::OrderReset;
      built_q       <= 1'b0;
      built_vars_q  <= '0;
      built_order_q <= '0;
      addr_q        <= '0;
      dim_q         <= '0;
      acc_q         <= '0;
      elig_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      coef_q        <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      var_cnt_q     <= var_cnt_d;
      exp_order_q   <= exp_order_d;
      built_q       <= built_d;
      built_vars_q  <= built_vars_d;
      built_order_q <= built_order_d;
      addr_q        <= addr_d;
      dim_q         <= dim_d;
      acc_q         <= acc_d;
      elig_q        <= elig_d;
      out_valid_q   <= out_valid_d;
      coef_q        <= coef_d;
      done_q        <= done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign build_done_o  = done_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multinomial coefficient table testbench
// Drives builds and coefficient queries through the valid/ready channels,
// predicts every result with an in-bench copy of the Pascal simplex, and
// compares each output transfer field by field. A short directed table opens
// the run; random phases under several register settings follow.
// ----------------------------------------------------------------------------
module testbench;
  import mct_pkg::*;

  localparam int GridCells     = 1 << AddrW;
  localparam longint CoefMax   = (longint'(1) << CoefWidth) - 1;
  localparam int PhaseCount    = 5;
  localparam int PhaseQueries  = 204;
  localparam int HoldOffCycles = 400;
  // Nine builds plus items and stalls, taken about four times over.
  localparam int RunLimit      = 4_000_000;

  typedef struct packed {
    logic                              mode;
    logic [GridDims-1:0][GridBits-1:0] expo;  // expo[0] is the first variable
  } coef_request_t;

  typedef struct packed {
    logic [OutCoefW-1:0] coefficient;
    logic                build_done;
  } coef_result_t;

  typedef enum logic {RowItem, RowConfig} row_kind_e;

  // A configuration row uses vars and order; an item row the other fields.
  // Rows with typed set carry their expected coefficient.
  typedef struct packed {
    row_kind_e           kind;
    logic [CfgDataW-1:0] vars;
    logic [CfgDataW-1:0] order;
    logic                mode;
    logic [GridBits-1:0] ea;
    logic [GridBits-1:0] eb;
    logic [GridBits-1:0] ec;
    logic [GridBits-1:0] ed;
    logic                typed;
    logic [OutCoefW-1:0] coef;
  } stim_row_t;

  localparam int DirectedCount = 29;
  localparam stim_row_t DirectedRows [DirectedCount] = '{
    // Nothing built yet: every query reads zero.
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd14, 4'd14, 4'd14, 4'd14, 1'b1, 23'd0},
    // Three variables, order four.
    '{RowItem,   4'd0, 4'd0,  ModeBuild, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 23'd1},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd2,  4'd1,  4'd1,  4'd0,  1'b0, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd4,  4'd0,  4'd0,  4'd0,  1'b1, 23'd1},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd0,  4'd0,  4'd4,  4'd0,  1'b1, 23'd1},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd2,  4'd2,  4'd1,  4'd0,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd0,  4'd0,  4'd0,  4'd1,  1'b1, 23'd0},
    // Registers widened after the build: cells outside the old simplex read zero.
    '{RowConfig, 4'd4, 4'd14, ModeQuery, 4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd1,  4'd1,  4'd1,  4'd1,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd1,  4'd1,  4'd0,  4'd0,  1'b0, 23'd0},
    // Full simplex: four variables, order fourteen.
    '{RowItem,   4'd0, 4'd0,  ModeBuild, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd14, 4'd0,  4'd0,  4'd0,  1'b1, 23'd1},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd0,  4'd0,  4'd0,  4'd14, 1'b1, 23'd1},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd4,  4'd4,  4'd3,  4'd3,  1'b0, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd14, 4'd0,  4'd0,  4'd1,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 23'd0},
    // A variable count of zero acts as one; order zero holds only the origin.
    '{RowConfig, 4'd0, 4'd0,  ModeQuery, 4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeBuild, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 23'd1},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd1,  4'd0,  4'd0,  4'd0,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd0,  4'd1,  4'd0,  4'd0,  1'b1, 23'd0},
    // Values above the limits clamp to four variables and order fourteen.
    '{RowConfig, 4'd7, 4'd15, ModeQuery, 4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd5,  4'd3,  4'd2,  4'd1,  1'b0, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd15, 4'd0,  4'd0,  4'd0,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeBuild, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 23'd0},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd14, 4'd0,  4'd0,  4'd0,  1'b1, 23'd1},
    '{RowItem,   4'd0, 4'd0,  ModeQuery, 4'd4,  4'd3,  4'd4,  4'd3,  1'b0, 23'd0}
  };

  // Clock, reset and block inputs, all known from time zero.
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index_i  = RegVarCount;
  logic [CfgDataW-1:0]   cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  mode_i       = ModeQuery;
  logic [GridBits-1:0]   exponent_a_i = '0;
  logic [GridBits-1:0]   exponent_b_i = '0;
  logic [GridBits-1:0]   exponent_c_i = '0;
  logic [GridBits-1:0]   exponent_d_i = '0;
  logic                  out_ready_i  = 1'b0;
  logic                  cfg_ready_o;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [OutCoefW-1:0]   coefficient_o;
  logic                  build_done_o;

  // Bench copy of the block state and registers.
  bit [CoefWidth-1:0]    coef_table [GridCells];
  logic [VarW-1:0]       var_count_reg = VarReset;
  logic [OrderW-1:0]     order_reg     = OrderReset;

  coef_result_t          expected_results [$];
  int                    requests_sent = 0;
  int                    results_seen  = 0;
  int                    mismatches    = 0;
  int                    cycle_count   = 0;

  multinomial_coefficient_table i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .exponent_a_i (exponent_a_i),
    .exponent_b_i (exponent_b_i),
    .exponent_c_i (exponent_c_i),
    .exponent_d_i (exponent_d_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coefficient_o(coefficient_o),
    .build_done_o (build_done_o)
  );

  always #5 clk_i = ~clk_i;

  // Effective variable count after clamping to 1..MaxVariables.
  function automatic int active_vars();
    if (var_count_reg == 0) return 1;
    if (var_count_reg > MaxVariables) return MaxVariables;
    return int'(var_count_reg);
  endfunction

  // Effective order after clamping to MaxOrder.
  function automatic int active_order();
    if (order_reg > MaxOrder) return MaxOrder;
    return int'(order_reg);
  endfunction

  // True when unused exponents are zero and the used ones sum to at most ord.
  function automatic logic in_simplex(input logic [GridDims-1:0][GridBits-1:0] expo,
                                      input int nv, input int ord, output int total);
    total = 0;
    for (int d = 0; d < GridDims; d++) begin
      if (d < nv) begin
        total += int'(expo[d]);
      end else if (expo[d] != '0) begin
        return 1'b0;
      end
    end
    return total <= ord;
  endfunction

  // Rebuilds the simplex in address order; every neighbor one step lower in
  // a dimension sits at a lower address, so one sweep fills all layers.
  function automatic void build_simplex();
    logic [GridDims-1:0][GridBits-1:0] node;
    int                                nv;
    int                                ord;
    int                                total;
    longint                            acc;
    nv  = active_vars();
    ord = active_order();
    for (int a = 0; a < GridCells; a++) coef_table[a] = '0;
    coef_table[0] = 1;
    for (int a = 1; a < GridCells; a++) begin
      node = a[AddrW-1:0];
      if (!in_simplex(node, nv, ord, total) || total == 0) continue;
      acc = 0;
      for (int d = 0; d < nv; d++) begin
        if (node[d] != '0) begin
          acc += longint'(coef_table[a - (1 << (d * GridBits))]);
          if (acc > CoefMax) acc = CoefMax;
        end
      end
      coef_table[a] = acc[CoefWidth-1:0];
    end
  endfunction

  // Expected result of one accepted item; a build also updates the table.
  function automatic coef_result_t predict_result(input coef_request_t req);
    coef_result_t res;
    int           total;
    res = '0;
    if (req.mode == ModeBuild) begin
      build_simplex();
      res.build_done = 1'b1;
    end else if (in_simplex(req.expo, active_vars(), active_order(), total)) begin
      res.coefficient = coef_table[req.expo][OutCoefW-1:0];
    end
    return res;
  endfunction

  // Per-item wait in cycles, with stretches of back-to-back traffic.
  function automatic int draw_gap(input int serial);
    if ((serial % 64) < 12) return 0;
    return int'($urandom_range(0, 6));
  endfunction

  // Offers one item and records its expectation at the input transfer.
  task automatic offer_request(input coef_request_t req, input logic typed,
                               input logic [OutCoefW-1:0] typed_coef);
    int           gap;
    coef_result_t res;
    gap = draw_gap(requests_sent);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= req.mode;
    exponent_a_i <= req.expo[0];
    exponent_b_i <= req.expo[1];
    exponent_c_i <= req.expo[2];
    exponent_d_i <= req.expo[3];
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_result(req);
    if (typed) begin
      res.coefficient = typed_coef;
      res.build_done  = (req.mode == ModeBuild);
    end
    expected_results.push_back(res);
    requests_sent++;
  endtask

  // Writes both registers once every outstanding result has been delivered.
  task automatic write_config(input logic [CfgDataW-1:0] vars,
                              input logic [CfgDataW-1:0] order);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegVarCount;
    cfg_data_i  <= vars;
    do @(posedge clk_i); while (!cfg_ready_o);
    var_count_reg = vars[VarW-1:0];
    cfg_index_i <= RegExpOrder;
    cfg_data_i  <= order;
    do @(posedge clk_i); while (!cfg_ready_o);
    order_reg = order[OrderW-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RunLimit) begin
      $display("%0t: run limit of %0d cycles reached", $time, RunLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, two long hold-offs, and the field checks.
  initial begin
    int           gap;
    coef_result_t want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(results_seen);
      if (results_seen == 150 || results_seen == 700) gap = HoldOffCycles;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output transfer: expected none, actual coefficient %0d "
                 , $time, coefficient_o, "build_done %0b", build_done_o);
      end else begin
        want = expected_results.pop_front();
        if (coefficient_o !== want.coefficient) begin
          mismatches++;
          $display("%0t: coefficient mismatch: expected %0d, actual %0d",
                   $time, want.coefficient, coefficient_o);
        end
        if (build_done_o !== want.build_done) begin
          mismatches++;
          $display("%0t: build_done mismatch: expected %0b, actual %0b",
                   $time, want.build_done, build_done_o);
        end
      end
    end
  end

  // Item side: reset, the directed table, then random phases.
  initial begin
    stim_row_t     row;
    coef_request_t req;
    int            nv;
    int            ord;
    int            budget;
    int            start;
    int            pick;
    int            d;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedCount; i++) begin
      row = DirectedRows[i];
      if (row.kind == RowConfig) begin
        write_config(row.vars, row.order);
      end else begin
        req.mode = row.mode;
        req.expo = {row.ed, row.ec, row.eb, row.ea};
        offer_request(req, row.typed, row.coef);
      end
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: write_config(4'd2, 4'($urandom_range(1, 13)));
        1: write_config(4'd1, 4'd14);
        2: write_config(4'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        3: write_config(4'd3, 4'd9);
        default: write_config(4'd4, 4'd14);
      endcase
      req = '0;
      req.mode = ModeBuild;
      req.expo = 16'($urandom);
      offer_request(req, 1'b0, '0);

      for (int n = 0; n < PhaseQueries; n++) begin
        // Sometimes change the registers without a rebuild halfway through.
        if (n == PhaseQueries / 2 && $urandom_range(0, 1) == 1) begin
          write_config(4'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        end
        nv   = active_vars();
        ord  = active_order();
        pick = int'($urandom_range(0, 9));
        req.mode = ModeQuery;
        req.expo = '0;
        if (pick < 7) begin
          // Tuple inside the current simplex, filled from a random dimension.
          budget = ord;
          start  = int'($urandom_range(0, nv - 1));
          for (int k = 0; k < nv; k++) begin
            d = (start + k) % nv;
            req.expo[d] = 4'($urandom_range(0, budget));
            budget -= int'(req.expo[d]);
          end
        end else if (pick == 7) begin
          // Used exponents only, usually past the order.
          for (int k = 0; k < nv; k++) req.expo[k] = 4'($urandom_range(0, 15));
        end else begin
          req.expo = 16'($urandom);
        end
        offer_request(req, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
